### rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants of the sensor frame builder: register indexes,
// frame layout positions and the structs passed between its modules.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned TempW   = 24;
  localparam int unsigned DistW   = 24;
  localparam int unsigned IndexW  = 8;

  // Configuration register indexes.
  localparam logic [IndexW-1:0] REG_MAGIC_HIGH     = 8'd0;
  localparam logic [IndexW-1:0] REG_MAGIC_LOW      = 8'd1;
  localparam logic [IndexW-1:0] REG_FRAME_TYPE     = 8'd2;
  localparam logic [IndexW-1:0] REG_PAYLOAD_LENGTH = 8'd3;

  localparam logic [ByteW-1:0] PAYLOAD_LENGTH_RESET = 8'd4;

  // Frame byte positions.
  localparam logic [PosW-1:0] POS_MAGIC_HIGH = 4'd0;
  localparam logic [PosW-1:0] POS_MAGIC_LOW  = 4'd1;
  localparam logic [PosW-1:0] POS_SEQUENCE   = 4'd2;
  localparam logic [PosW-1:0] POS_TYPE       = 4'd3;
  localparam logic [PosW-1:0] POS_LENGTH     = 4'd4;
  localparam logic [PosW-1:0] POS_TEMP_LO    = 4'd5;
  localparam logic [PosW-1:0] POS_TEMP_HI    = 4'd6;
  localparam logic [PosW-1:0] POS_DIST_LO    = 4'd7;
  localparam logic [PosW-1:0] POS_DIST_HI    = 4'd8;
  localparam logic [PosW-1:0] POS_CRC        = 4'd9;

  typedef struct packed {
    logic [ByteW-1:0] magic_high;
    logic [ByteW-1:0] magic_low;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] payload_length;
  } cfg_t;

  // One reading after scaling, ready to be serialized.
  typedef struct packed {
    logic [ByteW-1:0] sequence_low;
    logic [15:0]      temp16;
    logic [15:0]      dist16;
  } reading_t;

endpackage

### rtl/sensor_frame_builder_crc8_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc8_core
// Turns one sensor reading into a ten-byte binary frame with a CRC-8/SMBUS
// trailer, delivered one byte per request on the output channel.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  ----------------------------------------
//   in       in_valid / in_stall   sequence_low, temperature_q8, distance_q8
//   out      out_valid / out_stall frame_byte, byte_position, last_of_frame
//   cfg      cfg_we                cfg_index, cfg_data (no read-back)
//
// A reading is taken into an input register, scaled there, and loaded into
// the frame register of the serializer; its first byte then passes from the
// frame register into the output register. The output register sends one
// byte per cycle while out_stall is low, and readings follow one another
// without gaps. The next reading is accepted while the current frame is
// still being sent. Reset (rst, synchronous) empties both stages and sets
// the configuration registers to their defaults. A stall on the output
// holds the byte in place and, once the input register is full, stalls the
// input channel.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc8_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sfb_pkg::IndexW-1:0]        cfg_index,
  input  logic [sfb_pkg::ByteW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sfb_pkg::ByteW-1:0]         sequence_low,
  input  logic signed [sfb_pkg::TempW-1:0]  temperature_q8,
  input  logic [sfb_pkg::DistW-1:0]         distance_q8,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfb_pkg::ByteW-1:0]         frame_byte,
  output logic [sfb_pkg::PosW-1:0]          byte_position,
  output logic                              last_of_frame
);

  sfb_pkg::cfg_t      cfg;
  sfb_pkg::reading_t  reading;
  logic               load_valid;
  logic               load_ready;

  // Configuration registers. Writes to an index outside the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_high     <= '0;
      cfg.magic_low      <= '0;
      cfg.frame_type     <= '0;
      cfg.payload_length <= sfb_pkg::PAYLOAD_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfb_pkg::REG_MAGIC_HIGH:     cfg.magic_high     <= cfg_data;
        sfb_pkg::REG_MAGIC_LOW:      cfg.magic_low      <= cfg_data;
        sfb_pkg::REG_FRAME_TYPE:     cfg.frame_type     <= cfg_data;
        sfb_pkg::REG_PAYLOAD_LENGTH: cfg.payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register and scaling to hundredths of a degree and tenths of a cm.
  sfb_scale u_scale (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sequence_low   (sequence_low),
    .temperature_q8 (temperature_q8),
    .distance_q8    (distance_q8),
    .load_ready     (load_ready),
    .load_valid     (load_valid),
    .reading        (reading)
  );

  // Frame sequencer: picks each byte in order, folds bytes two through
  // eight into the CRC, and places the CRC as the closing byte.
  sfb_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .load_valid    (load_valid),
    .load_ready    (load_ready),
    .reading       (reading),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_of_frame (last_of_frame)
  );

endmodule

### rtl/sfb_scale.sv
// ----------------------------------------------------------------------------
// sfb_scale
// Input register and fixed-point scaling of temperature and distance.
// ----------------------------------------------------------------------------
module sfb_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sfb_pkg::ByteW-1:0]      sequence_low,
  input  logic signed [sfb_pkg::TempW-1:0] temperature_q8,
  input  logic [sfb_pkg::DistW-1:0]      distance_q8,
  input  logic                           load_ready,
  output logic                           load_valid,
  output sfb_pkg::reading_t              reading
);

  logic                         held;
  logic [sfb_pkg::ByteW-1:0]    seq_q;
  logic [sfb_pkg::TempW-1:0]    temp_q;
  logic [sfb_pkg::DistW-1:0]    dist_q;

  logic [sfb_pkg::TempW-1:0]    temp_mag;
  logic [30:0]                  temp_prod;
  logic [22:0]                  temp_q_mag;
  logic [15:0]                  temp16;
  logic [27:0]                  dist_prod;
  logic [19:0]                  dist_q_mag;
  logic [15:0]                  dist16;
  logic                         accept;

  assign load_valid = held;
  assign in_stall   = held && !load_ready;
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (load_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_q  <= sequence_low;
      temp_q <= temperature_q8;
      dist_q <= distance_q8;
    end
  end

  // Rounding is half away from zero on the magnitude, then the sign returns.
  always_comb begin
    temp_mag   = temp_q[sfb_pkg::TempW-1] ? (~temp_q + 24'd1) : temp_q;
    temp_prod  = 31'(temp_mag) * 31'd100;
    temp_q_mag = 23'((temp_prod + 31'd128) >> 8);
    if (temp_q[sfb_pkg::TempW-1]) begin
      if (temp_q_mag > 23'd32768) begin
        temp16 = 16'h8000;
      end else begin
        temp16 = ~temp_q_mag[15:0] + 16'd1;
      end
    end else begin
      if (temp_q_mag > 23'd32767) begin
        temp16 = 16'h7fff;
      end else begin
        temp16 = temp_q_mag[15:0];
      end
    end

    dist_prod  = 28'(dist_q) * 28'd10;
    dist_q_mag = 20'((dist_prod + 28'd128) >> 8);
    if (dist_q_mag > 20'd65535) begin
      dist16 = 16'hffff;
    end else begin
      dist16 = dist_q_mag[15:0];
    end
  end

  assign reading.sequence_low = seq_q;
  assign reading.temp16       = temp16;
  assign reading.dist16       = dist16;

endmodule

### rtl/sfb_serial.sv
// ----------------------------------------------------------------------------
// sfb_serial
// Frame holding register, byte sequencer, running CRC-8 and output register.
// ----------------------------------------------------------------------------
module sfb_serial (
  input  logic                          clk,
  input  logic                          rst,
  input  sfb_pkg::cfg_t                 cfg,
  input  logic                          load_valid,
  output logic                          load_ready,
  input  sfb_pkg::reading_t             reading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfb_pkg::ByteW-1:0]     frame_byte,
  output logic [sfb_pkg::PosW-1:0]      byte_position,
  output logic                          last_of_frame
);

  logic                         active;
  logic [sfb_pkg::PosW-1:0]     pos;
  logic [sfb_pkg::PosW-1:0]     pos_next;
  sfb_pkg::reading_t            frame;
  logic [sfb_pkg::ByteW-1:0]    crc;
  logic [sfb_pkg::ByteW-1:0]    crc_next;
  logic [sfb_pkg::ByteW-1:0]    cur_byte;
  logic                         out_free;
  logic                         emit;
  logic                         load;

  // One CRC-8 byte step, polynomial 0x07, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ((v << 1) ^ 8'h07) : (v << 1);
    end
    return v;
  endfunction

  assign out_free   = !out_valid || !out_stall;
  assign emit       = active && out_free;
  assign load_ready = !active || (emit && pos == sfb_pkg::POS_CRC);
  assign load       = load_valid && load_ready;
  assign pos_next   = pos + 4'd1;

  always_comb begin
    case (pos)
      sfb_pkg::POS_MAGIC_HIGH: cur_byte = cfg.magic_high;
      sfb_pkg::POS_MAGIC_LOW:  cur_byte = cfg.magic_low;
      sfb_pkg::POS_SEQUENCE:   cur_byte = frame.sequence_low;
      sfb_pkg::POS_TYPE:       cur_byte = cfg.frame_type;
      sfb_pkg::POS_LENGTH:     cur_byte = cfg.payload_length;
      sfb_pkg::POS_TEMP_LO:    cur_byte = frame.temp16[7:0];
      sfb_pkg::POS_TEMP_HI:    cur_byte = frame.temp16[15:8];
      sfb_pkg::POS_DIST_LO:    cur_byte = frame.dist16[7:0];
      sfb_pkg::POS_DIST_HI:    cur_byte = frame.dist16[15:8];
      default:                 cur_byte = crc;
    endcase
  end

  // The CRC covers the sequence byte through the high distance byte.
  always_comb begin
    if (pos inside {[sfb_pkg::POS_SEQUENCE:sfb_pkg::POS_DIST_HI]}) begin
      crc_next = crc8_step(crc, cur_byte);
    end else begin
      crc_next = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pos       <= sfb_pkg::POS_MAGIC_HIGH;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
        pos    <= sfb_pkg::POS_MAGIC_HIGH;
      end else if (emit) begin
        if (pos == sfb_pkg::POS_CRC) begin
          active <= 1'b0;
        end
        pos <= pos_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= reading;
      crc   <= 8'h00;
    end else if (emit) begin
      crc <= crc_next;
    end
    if (emit) begin
      frame_byte    <= cur_byte;
      byte_position <= pos;
      last_of_frame <= (pos == sfb_pkg::POS_CRC);
    end
  end

  a_last_on_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_frame == (byte_position == sfb_pkg::POS_CRC)))
    else $error("last_of_frame does not match the CRC position");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (pos <= sfb_pkg::POS_CRC))
    else $error("byte sequencer ran past the CRC byte");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && byte_position == $past(pos)))
    else $error("emitted byte did not reach the output register");

  a_no_load_midframe: assert property (@(posedge clk) disable iff (rst)
    (active && pos != sfb_pkg::POS_CRC) |-> !load)
    else $error("new reading loaded in the middle of a frame");

endmodule
